@@ sv/frustum_cull_test_top_defines.svh @@
// Assertion macros for the frustum cull test block.
`ifndef FRUSTUM_CULL_TEST_TOP_DEFINES_SVH
`define FRUSTUM_CULL_TEST_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define FCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also looks at reset itself.
`define FCT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fct_pkg.sv @@
package fct_pkg;

    localparam int PLANE_W    = 64;
    localparam int COEF_W     = 12;
    localparam int D_W        = 28;
    localparam int POS_W      = 24;
    localparam int EXT_W      = 23;
    localparam int PROD_W     = COEF_W + POS_W;
    localparam int MAG_PROD_W = COEF_W + EXT_W;
    localparam int SUM_W      = 42;
    localparam int D_SHIFT    = 10;
    localparam int REG_COUNT  = 6;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        FUNC_POINT  = 2'd0,
        FUNC_CUBE   = 2'd1,
        FUNC_SPHERE = 2'd2,
        FUNC_BOX    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_NEAR   = 3'd0,
        REG_PLANE_FAR    = 3'd1,
        REG_PLANE_LEFT   = 3'd2,
        REG_PLANE_RIGHT  = 3'd3,
        REG_PLANE_TOP    = 3'd4,
        REG_PLANE_BOTTOM = 3'd5
    } cfg_reg_t;

    // stage load enables
    typedef struct packed {
        logic en1;
        logic en2;
        logic en_out;
    } pipe_en_t;

endpackage

@@ sv/frustum_cull_test_top.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------
// s_       | in        | s_valid / s_ready  | func, pos_x/y/z, ext_x/y/z
// m_       | out       | m_valid / m_ready  | visible
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata (six planes)
//
// One item per cycle while the output is not stalled; each result passes the
// stage 1, stage 2 and output registers before m_valid shows it.
// Each item passes the multiply, sum and compare stages of each plane lane.
// aresetn clears the valid bits, the output register and the planes.
// A stalled output holds; earlier stages keep filling any empty slot.
module frustum_cull_test_top #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_func,
    input  logic signed [fct_pkg::POS_W-1:0]      s_pos_x,
    input  logic signed [fct_pkg::POS_W-1:0]      s_pos_y,
    input  logic signed [fct_pkg::POS_W-1:0]      s_pos_z,
    input  logic [fct_pkg::EXT_W-1:0]             s_ext_x,
    input  logic [fct_pkg::EXT_W-1:0]             s_ext_y,
    input  logic [fct_pkg::EXT_W-1:0]             s_ext_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_visible
);
    import fct_pkg::*;

    pipe_en_t             en;
    logic [PLANE_W-1:0]   planes_reg [REG_COUNT];
    func_t                func_in;
    func_t                func_s1_reg;
    logic [EXT_W-1:0]     radius_s1_reg;
    logic [EXT_W-1:0]     ext_y_sel, ext_z_sel;
    logic [PLANE_COUNT-1:0] cull;
    logic                 visible_reg, visible_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                planes_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_PLANE_NEAR:   planes_reg[0] <= cfg_wdata;
                REG_PLANE_FAR:    planes_reg[1] <= cfg_wdata;
                REG_PLANE_LEFT:   planes_reg[2] <= cfg_wdata;
                REG_PLANE_RIGHT:  planes_reg[3] <= cfg_wdata;
                REG_PLANE_TOP:    planes_reg[4] <= cfg_wdata;
                REG_PLANE_BOTTOM: planes_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fct_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    // a cube uses its one half size on every axis
    assign func_in   = func_t'(s_func);
    assign ext_y_sel = (func_in == FUNC_CUBE) ? s_ext_x : s_ext_y;
    assign ext_z_sel = (func_in == FUNC_CUBE) ? s_ext_x : s_ext_z;

    always_ff @(posedge aclk) begin
        if (en.en1) begin
            func_s1_reg   <= func_in;
            radius_s1_reg <= s_ext_x;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
        fct_plane_lane u_lane (
            .aclk      (aclk),
            .en        (en),
            .plane     (planes_reg[g]),
            .pos_x     (s_pos_x),
            .pos_y     (s_pos_y),
            .pos_z     (s_pos_z),
            .ext_x     (s_ext_x),
            .ext_y     (ext_y_sel),
            .ext_z     (ext_z_sel),
            .func_s1   (func_s1_reg),
            .radius_s1 (radius_s1_reg),
            .cull      (cull[g])
        );
    end

    assign visible_next = ~|cull;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visible_reg <= 1'b0;
        end else if (en.en_out) begin
            visible_reg <= visible_next;
        end
    end

    assign m_visible = visible_reg;

endmodule

@@ sv/fct_pipe_ctrl.sv @@
module fct_pipe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fct_pkg::pipe_en_t en
);
    import fct_pkg::*;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic vout_reg, vout_next;

    // each stage moves when the one after it is empty or moving
    always_comb begin
        en.en_out = !vout_reg || m_ready;
        en.en2    = !v2_reg || en.en_out;
        en.en1    = !v1_reg || en.en2;
    end

    always_comb begin
        v1_next   = en.en1    ? s_valid : v1_reg;
        v2_next   = en.en2    ? v1_reg  : v2_reg;
        vout_next = en.en_out ? v2_reg  : vout_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            vout_reg <= vout_next;
        end
    end

    assign s_ready = en.en1;
    assign m_valid = vout_reg;

endmodule

@@ sv/fct_plane_lane.sv @@
module fct_plane_lane (
    input  logic                                 aclk,
    input  fct_pkg::pipe_en_t                    en,
    input  logic [fct_pkg::PLANE_W-1:0]          plane,
    input  logic signed [fct_pkg::POS_W-1:0]     pos_x,
    input  logic signed [fct_pkg::POS_W-1:0]     pos_y,
    input  logic signed [fct_pkg::POS_W-1:0]     pos_z,
    input  logic [fct_pkg::EXT_W-1:0]            ext_x,
    input  logic [fct_pkg::EXT_W-1:0]            ext_y,
    input  logic [fct_pkg::EXT_W-1:0]            ext_z,
    input  fct_pkg::func_t                       func_s1,
    input  logic [fct_pkg::EXT_W-1:0]            radius_s1,
    output logic                                 cull
);
    import fct_pkg::*;

    logic signed [COEF_W-1:0] a_coef, b_coef, c_coef;
    logic signed [D_W-1:0]    d_coef;
    logic [COEF_W-1:0]        a_mag, b_mag, c_mag;

    logic signed [PROD_W-1:0] prod_ax_reg, prod_ax_next;
    logic signed [PROD_W-1:0] prod_by_reg, prod_by_next;
    logic signed [PROD_W-1:0] prod_cz_reg, prod_cz_next;
    logic [MAG_PROD_W-1:0]    mag_ax_reg, mag_ax_next;
    logic [MAG_PROD_W-1:0]    mag_by_reg, mag_by_next;
    logic [MAG_PROD_W-1:0]    mag_cz_reg, mag_cz_next;

    logic signed [SUM_W-1:0]  center_reg, center_next;
    logic signed [SUM_W-1:0]  adj_reg, adj_next;
    logic [SUM_W-1:0]         mag_sum;
    logic signed [SUM_W-1:0]  margin;

    assign a_coef = plane[COEF_W-1:0];
    assign b_coef = plane[2*COEF_W-1:COEF_W];
    assign c_coef = plane[3*COEF_W-1:2*COEF_W];
    assign d_coef = plane[PLANE_W-1:3*COEF_W];

    assign a_mag = a_coef[COEF_W-1] ? (~a_coef + 1'b1) : a_coef;
    assign b_mag = b_coef[COEF_W-1] ? (~b_coef + 1'b1) : b_coef;
    assign c_mag = c_coef[COEF_W-1] ? (~c_coef + 1'b1) : c_coef;

    // stage 1: plane products at the centre and worst-case extent terms
    always_comb begin
        prod_ax_next = PROD_W'(a_coef) * PROD_W'(pos_x);
        prod_by_next = PROD_W'(b_coef) * PROD_W'(pos_y);
        prod_cz_next = PROD_W'(c_coef) * PROD_W'(pos_z);
        mag_ax_next  = MAG_PROD_W'(a_mag) * MAG_PROD_W'(ext_x);
        mag_by_next  = MAG_PROD_W'(b_mag) * MAG_PROD_W'(ext_y);
        mag_cz_next  = MAG_PROD_W'(c_mag) * MAG_PROD_W'(ext_z);
    end

    always_ff @(posedge aclk) begin
        if (en.en1) begin
            prod_ax_reg <= prod_ax_next;
            prod_by_reg <= prod_by_next;
            prod_cz_reg <= prod_cz_next;
            mag_ax_reg  <= mag_ax_next;
            mag_by_reg  <= mag_by_next;
            mag_cz_reg  <= mag_cz_next;
        end
    end

    // stage 2: centre value and the slack the query kind allows
    always_comb begin
        center_next = SUM_W'(prod_ax_reg) + SUM_W'(prod_by_reg) + SUM_W'(prod_cz_reg)
                    + (SUM_W'(d_coef) <<< D_SHIFT);
        mag_sum     = SUM_W'(mag_ax_reg) + SUM_W'(mag_by_reg) + SUM_W'(mag_cz_reg);
        case (func_s1)
            FUNC_POINT:  adj_next = '0;
            FUNC_SPHERE: adj_next = signed'(SUM_W'(radius_s1) << D_SHIFT);
            default:     adj_next = signed'(mag_sum);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            center_reg <= center_next;
            adj_reg    <= adj_next;
        end
    end

    // best corner, centre plus radius, or the point itself, still behind the plane
    assign margin = center_reg + adj_reg;
    assign cull   = margin[SUM_W-1];

endmodule

@@ sv/fct_checker.sv @@
`include "frustum_cull_test_top_defines.svh"

module fct_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_visible
);

    `FCT_ASSERT_RST(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

    `FCT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_visible), "stalled result changed")

    `FCT_ASSERT_SAME(a_full_stall, !s_ready, m_valid && !m_ready, "input blocked without a full stalled pipe")

    `FCT_ASSERT_NEXT(a_latency, (s_valid && s_ready) ##1 m_ready ##1 m_ready, m_valid, "item missing three cycles after acceptance")

endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (.*);
